@@ src/spq_pkg.sv @@
// ----------------------------------------------------------------------------
// spq_pkg
// Shared constants, codes and types of the sorted priority queue.
// ----------------------------------------------------------------------------
package spq_pkg;

  // queue geometry
  localparam int QUEUE_DEPTH = 16;
  localparam int TAG_BITS    = 32;
  localparam int IDX_W       = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

  // fixed field widths of the channels
  localparam int REQ_W  = 2;
  localparam int PRIO_W = 8;
  localparam int TAG_W  = 32;
  localparam int STAT_W = 2;
  localparam int OCC_W  = 5;

  // request codes
  typedef enum logic [REQ_W-1:0] {
    REQ_ENQ    = 2'd0,
    REQ_DEQ    = 2'd1,
    REQ_PEEK   = 2'd2,
    REQ_UNUSED = 2'd3
  } req_t;

  // status codes
  typedef enum logic [STAT_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_ZERO  = 2'd2,
    STAT_EMPTY = 2'd3
  } status_t;

  // one stored job
  typedef struct packed {
    logic [PRIO_W-1:0]   prio;
    logic [TAG_BITS-1:0] tag;
  } slot_t;

  // sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SHIFT,
    ST_PLACE,
    ST_DEQ
  } state_t;

endpackage

@@ src/spq_if.sv @@
// ----------------------------------------------------------------------------
// spq_req_if / spq_rsp_if
// Valid/ready channels for requests and results of the priority queue.
// ----------------------------------------------------------------------------
interface spq_req_if
  import spq_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [REQ_W-1:0]  req_type;
  logic [PRIO_W-1:0] job_priority;
  logic [TAG_W-1:0]  job_tag;

  modport source (output valid, output req_type, output job_priority, output job_tag,
                  input ready);
  modport sink   (input valid, input req_type, input job_priority, input job_tag,
                  output ready);
endinterface

interface spq_rsp_if
  import spq_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [STAT_W-1:0] status;
  logic [PRIO_W-1:0] out_priority;
  logic [TAG_W-1:0]  out_tag;
  logic [OCC_W-1:0]  occupancy;
  logic [OCC_W-1:0]  free_slots;
  logic              is_full;
  logic              is_empty;

  modport source (output valid, output status, output out_priority, output out_tag,
                  output occupancy, output free_slots, output is_full, output is_empty,
                  input ready);
  modport sink   (input valid, input status, input out_priority, input out_tag,
                  input occupancy, input free_slots, input is_full, input is_empty,
                  output ready);
endinterface

@@ src/spq_slot_ram.sv @@
// ----------------------------------------------------------------------------
// spq_slot_ram
// Slot store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module spq_slot_ram
  import spq_pkg::*;
(
  input  logic             clk,
  input  logic             wr_en,
  input  logic [IDX_W-1:0] wr_addr,
  input  slot_t            wr_data,
  input  logic             rd_en,
  input  logic [IDX_W-1:0] rd_addr,
  output slot_t            rd_data
);

  slot_t mem [QUEUE_DEPTH];
  slot_t rd_data_r;

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read port, registered read data
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

@@ src/sorted_priority_queue.sv @@
// ----------------------------------------------------------------------------
// sorted_priority_queue
// Bounded priority queue kept sorted in a slot memory; smallest nonzero
// priority served first, first-in first-out among equal priorities.
// ----------------------------------------------------------------------------
// Usage:
//   in_req  carries one request item (enqueue, dequeue or peek) per handshake.
//   out_rsp returns exactly one result item per request: status, returned
//   job, occupancy, free slots and the full and empty flags after the request.
//   Slots 0..count-1 hold jobs in non-increasing priority value; the best job
//   sits in slot count-1. An enqueue walks down from the top through the
//   slot memory (one read and one write port), moving one entry up per cycle
//   until its place is found.
// Completion (accept to result valid):
//   rejected enqueue, unused code, empty dequeue/peek, enqueue into empty:
//   result registered at accept; dequeue or peek: after one memory read;
//   enqueue: after one read, then one shift step per stored job with
//   priority value <= new one, then the final write.
// Throughput: one item at a time; the next item is taken in the cycle its
//   predecessor's result is taken at the earliest.
// Reset: synchronous active-low rst_n empties the queue; slot contents are
//   not cleared. A stalled receiver holds the result register and blocks
//   new requests until the result is taken.
// ----------------------------------------------------------------------------
module sorted_priority_queue
  import spq_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  spq_req_if.sink    in_req,
  spq_rsp_if.source  out_rsp
);

  // control state
  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  slot_t            new_r, new_nxt;
  logic             pop_r, pop_nxt;

  // result register
  logic              out_valid_r;
  logic [STAT_W-1:0] status_r;
  logic [PRIO_W-1:0] prio_out_r;
  logic [TAG_W-1:0]  tag_out_r;
  logic [OCC_W-1:0]  occ_r;
  logic [OCC_W-1:0]  free_r;
  logic              full_r;
  logic              empty_r;

  // memory port signals
  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr;
  slot_t            mem_wdata;
  logic             mem_re;
  logic [IDX_W-1:0] mem_raddr;
  slot_t            mem_rdata;

  logic              accept;
  logic              done;
  status_t           res_status;
  slot_t             res_job;
  req_t              req;
  slot_t             in_job;
  logic              is_full_now;
  logic [CNT_W-1:0]  count_dec;

  spq_slot_ram u_slot_ram (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (mem_waddr),
    .wr_data (mem_wdata),
    .rd_en   (mem_re),
    .rd_addr (mem_raddr),
    .rd_data (mem_rdata)
  );

  // handshake; new items wait while the sequencer is busy (interlock)
  assign in_req.ready = (state_r == ST_IDLE) && (!out_valid_r || out_rsp.ready);
  assign accept       = in_req.valid && in_req.ready;
  assign req          = req_t'(in_req.req_type);
  assign in_job.prio  = in_req.job_priority;
  assign in_job.tag   = TAG_BITS'(in_req.job_tag);
  assign is_full_now  = (count_r == CNT_W'(QUEUE_DEPTH));
  assign count_dec    = count_r - CNT_W'(1);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          unique case (req)
            REQ_ENQ: begin
              if (!is_full_now && (in_job.prio != '0) && (count_r != '0)) begin
                state_nxt = ST_SHIFT;
              end
            end
            REQ_DEQ, REQ_PEEK: begin
              if (count_r != '0) begin
                state_nxt = ST_DEQ;
              end
            end
            default: state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_SHIFT: begin
        if (mem_rdata.prio <= new_r.prio) begin
          if (idx_r == IDX_W'(1)) begin
            state_nxt = ST_PLACE;
          end
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_PLACE: state_nxt = ST_IDLE;
      ST_DEQ:   state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    count_nxt  = count_r;
    idx_nxt    = idx_r;
    new_nxt    = new_r;
    pop_nxt    = pop_r;
    mem_we     = 1'b0;
    mem_waddr  = idx_r;
    mem_wdata  = new_r;
    mem_re     = 1'b0;
    mem_raddr  = IDX_W'(count_dec);
    done       = 1'b0;
    res_status = STAT_OK;
    res_job    = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          new_nxt = in_job;
          idx_nxt = IDX_W'(count_r);
          pop_nxt = (req == REQ_DEQ);
          unique case (req)
            REQ_ENQ: begin
              if (is_full_now) begin
                done       = 1'b1;
                res_status = STAT_FULL;
              end else if (in_job.prio == '0) begin
                done       = 1'b1;
                res_status = STAT_ZERO;
              end else if (count_r == '0) begin
                // empty queue: place straight into slot 0
                mem_we    = 1'b1;
                mem_waddr = '0;
                mem_wdata = in_job;
                done      = 1'b1;
                count_nxt = CNT_W'(1);
              end else begin
                mem_re = 1'b1;
              end
            end
            REQ_DEQ, REQ_PEEK: begin
              if (count_r == '0) begin
                done       = 1'b1;
                res_status = STAT_EMPTY;
              end else begin
                mem_re = 1'b1;
              end
            end
            default: done = 1'b1;
          endcase
        end
      end
      ST_SHIFT: begin
        // read data is slot idx_r-1
        mem_we = 1'b1;
        if (mem_rdata.prio <= new_r.prio) begin
          mem_wdata = mem_rdata;
          idx_nxt   = idx_r - IDX_W'(1);
          if (idx_r != IDX_W'(1)) begin
            mem_re    = 1'b1;
            mem_raddr = idx_r - IDX_W'(2);
          end
        end else begin
          done      = 1'b1;
          count_nxt = count_r + CNT_W'(1);
        end
      end
      ST_PLACE: begin
        mem_we    = 1'b1;
        done      = 1'b1;
        count_nxt = count_r + CNT_W'(1);
      end
      ST_DEQ: begin
        done    = 1'b1;
        res_job = mem_rdata;
        if (pop_r) begin
          count_nxt = count_dec;
        end
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    new_r <= new_nxt;
    pop_r <= pop_nxt;
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (done) begin
      out_valid_r <= 1'b1;
    end else if (out_rsp.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      status_r   <= res_status;
      prio_out_r <= res_job.prio;
      tag_out_r  <= TAG_W'(res_job.tag);
      occ_r      <= OCC_W'(count_nxt);
      free_r     <= OCC_W'(CNT_W'(QUEUE_DEPTH) - count_nxt);
      full_r     <= (count_nxt == CNT_W'(QUEUE_DEPTH));
      empty_r    <= (count_nxt == '0);
    end
  end

  assign out_rsp.valid        = out_valid_r;
  assign out_rsp.status       = status_r;
  assign out_rsp.out_priority = prio_out_r;
  assign out_rsp.out_tag      = tag_out_r;
  assign out_rsp.occupancy    = occ_r;
  assign out_rsp.free_slots   = free_r;
  assign out_rsp.is_full      = full_r;
  assign out_rsp.is_empty     = empty_r;

`ifndef NO_ASSERTIONS
  // occupancy never exceeds capacity
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(QUEUE_DEPTH))
    else $error("queue count above capacity");

  // count moves by at most one per cycle
  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == $past(count_r)) || (count_r == $past(count_r) + CNT_W'(1)) ||
    (count_r == $past(count_r) - CNT_W'(1)))
    else $error("queue count jumped");

  // a result never overwrites one still waiting
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_rsp.ready) |-> !done)
    else $error("result register overrun");

  // the shift walk never reaches below slot 0
  a_shift_idx: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SHIFT) |-> (idx_r != '0))
    else $error("shift walk index underflow");
`endif

endmodule

@@ test/spq_checker.sv @@
// ----------------------------------------------------------------------------
// spq_checker
// Watches the request and result channels of the priority queue, keeps its
// own sorted copy of the queued jobs and compares every result item with the
// one that the accepted request should have produced.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module spq_checker
  import spq_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  spq_req_if          req,
  spq_rsp_if          rsp,
  output int unsigned outstanding,
  output int unsigned mismatches
);

  // one expected result item
  typedef struct {
    status_t           status;
    logic [PRIO_W-1:0] prio;
    logic [TAG_W-1:0]  tag;
    logic [OCC_W-1:0]  occ;
    logic [OCC_W-1:0]  free;
    logic              full;
    logic              empty;
  } queue_result_t;

  // shadow queue: slots 0..job_count-1 in non-increasing priority value
  logic [PRIO_W-1:0]   job_prio [QUEUE_DEPTH];
  logic [TAG_BITS-1:0] job_tag  [QUEUE_DEPTH];
  int unsigned         job_count;

  queue_result_t awaited_results [$];
  int unsigned   err_count;

  assign mismatches = err_count;

  // apply one request to the shadow queue and return its result
  function automatic queue_result_t serve_request(input req_t kind,
                                                  input logic [PRIO_W-1:0] prio,
                                                  input logic [TAG_W-1:0] tag);
    queue_result_t r;
    int unsigned   pos;
    int unsigned   i;
    r.status = STAT_OK;
    r.prio   = '0;
    r.tag    = '0;
    case (kind)
      REQ_ENQ: begin
        if (job_count >= QUEUE_DEPTH) begin
          r.status = STAT_FULL;
        end else if (prio == '0) begin
          r.status = STAT_ZERO;
        end else begin
          // new job goes below every job with priority value <= its own
          pos = job_count;
          for (i = job_count; i > 0; i--) begin
            if (job_prio[i-1] <= prio) pos = i - 1;
          end
          for (i = job_count; i > pos; i--) begin
            job_prio[i] = job_prio[i-1];
            job_tag[i]  = job_tag[i-1];
          end
          job_prio[pos] = prio;
          job_tag[pos]  = tag[TAG_BITS-1:0];
          job_count++;
        end
      end
      REQ_DEQ, REQ_PEEK: begin
        if (job_count == 0) begin
          r.status = STAT_EMPTY;
        end else begin
          // best job sits at the top
          r.prio = job_prio[job_count-1];
          r.tag  = TAG_W'(job_tag[job_count-1]);
          if (kind == REQ_DEQ) job_count--;
        end
      end
      default: ;
    endcase
    r.occ   = OCC_W'(job_count);
    r.free  = OCC_W'(QUEUE_DEPTH - job_count);
    r.full  = (job_count == QUEUE_DEPTH);
    r.empty = (job_count == 0);
    return r;
  endfunction

  task automatic check_field(input string field, input logic [TAG_W-1:0] want,
                             input logic [TAG_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", field, want, got);
      err_count++;
    end
  endtask

  // results are taken before requests: a result never leaves in its own cycle
  always @(posedge clk) begin : monitor
    queue_result_t want;
    int unsigned   i;
    if (!rst_n) begin
      job_count = 0;
      for (i = 0; i < QUEUE_DEPTH; i++) begin
        job_prio[i] = '0;
        job_tag[i]  = '0;
      end
      awaited_results.delete();
    end else begin
      if (rsp.valid && rsp.ready) begin
        if (awaited_results.size() == 0) begin
          $error("result item with no request outstanding");
          err_count++;
        end else begin
          want = awaited_results.pop_front();
          check_field("status",       want.status, rsp.status);
          check_field("out_priority", want.prio,   rsp.out_priority);
          check_field("out_tag",      want.tag,    rsp.out_tag);
          check_field("occupancy",    want.occ,    rsp.occupancy);
          check_field("free_slots",   want.free,   rsp.free_slots);
          check_field("is_full",      want.full,   rsp.is_full);
          check_field("is_empty",     want.empty,  rsp.is_empty);
        end
      end
      if (req.valid && req.ready) begin
        awaited_results.push_back(serve_request(req_t'(req.req_type), req.job_priority,
                                                req.job_tag));
      end
    end
    outstanding <= awaited_results.size();
  end

endmodule

@@ test/sorted_priority_queue_test.sv @@
// ----------------------------------------------------------------------------
// sorted_priority_queue_test
// Drives requests into the priority queue and takes its results under
// several idle and stall patterns; a checker beside the block predicts and
// compares every result item.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sorted_priority_queue_test;
  import spq_pkg::*;

  localparam int CLK_PERIOD  = 12;
  localparam int RESET_CYCLES = 12;
  localparam int LONG_STALL  = 80;
  localparam int BURSTS      = 6;
  localparam int BURST_ITEMS = 28;
  localparam int CYCLE_LIMIT = 400000;

  logic clk = 1'b0;
  logic rst_n;

  spq_req_if in_req ();
  spq_rsp_if out_rsp ();

  int unsigned outstanding;
  int unsigned mismatches;
  int unsigned idle_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned stalls_asked = 0;
  int unsigned stalls_served = 0;
  int unsigned cycle_count = 0;

  // priorities of the directed fill: extremes, ties and out-of-order values
  logic [PRIO_W-1:0] fill_prio [QUEUE_DEPTH] = '{
    8'd255, 8'd1, 8'd128, 8'd128, 8'd1, 8'd64, 8'd255, 8'd2,
    8'd128, 8'd127, 8'd1, 8'd200, 8'd3, 8'd128, 8'd254, 8'd1
  };

  always #(CLK_PERIOD/2) clk = ~clk;

  sorted_priority_queue u_top (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (in_req),
    .out_rsp (out_rsp)
  );

  spq_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .req         (in_req),
    .rsp         (out_rsp),
    .outstanding (outstanding),
    .mismatches  (mismatches)
  );

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // result side: random stalls, or a long counted hold-off when asked
  initial begin
    out_rsp.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (stalls_served != stalls_asked) begin
        stalls_served++;
        out_rsp.ready <= 1'b0;
        repeat (LONG_STALL - 1) @(posedge clk);
      end else begin
        out_rsp.ready <= ($urandom_range(0, 99) >= stall_pct);
      end
    end
  end

  // offer one item, with random idle cycles ahead of it
  task automatic send(input req_t kind, input logic [PRIO_W-1:0] prio,
                      input logic [TAG_W-1:0] tag);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_req.valid <= 1'b0;
      @(posedge clk);
    end
    in_req.valid        <= 1'b1;
    in_req.req_type     <= kind;
    in_req.job_priority <= prio;
    in_req.job_tag      <= tag;
    @(posedge clk);
    while (!in_req.ready) @(posedge clk);
  endtask

  // random request, biased toward filling or draining the queue
  task automatic send_random(input bit filling);
    int unsigned       roll;
    req_t              kind;
    logic [PRIO_W-1:0] prio;
    roll = $urandom_range(0, 99);
    if (roll < 4) kind = REQ_UNUSED;
    else if (roll < 14) kind = REQ_PEEK;
    else if (roll < (filling ? 80 : 35)) kind = REQ_ENQ;
    else kind = REQ_DEQ;
    roll = $urandom_range(0, 99);
    // mostly a few small values so that equal priorities meet often
    if (roll < 5) prio = '0;
    else if (roll < 60) prio = PRIO_W'($urandom_range(1, 6));
    else prio = PRIO_W'($urandom_range(1, 255));
    send(kind, prio, $urandom);
  endtask

  // stop offering until every result item has come back
  task automatic drain();
    in_req.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  // stimulus and verdict
  initial begin
    int phase;
    int burst;
    int k;
    rst_n               <= 1'b0;
    in_req.valid        <= 1'b0;
    in_req.req_type     <= REQ_ENQ;
    in_req.job_priority <= '0;
    in_req.job_tag      <= '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty queue: peek, dequeue, unused code, zero priority
    send(REQ_PEEK, 8'd9, 32'h1234_5678);
    send(REQ_DEQ, 8'd255, 32'hFFFF_FFFF);
    send(REQ_UNUSED, 8'hFF, 32'hFFFF_FFFF);
    send(REQ_ENQ, 8'd0, 32'hDEAD_BEEF);
    // fill to capacity
    for (k = 0; k < QUEUE_DEPTH; k++) begin
      send(REQ_ENQ, fill_prio[k], (k == 0) ? 32'h0 : (k == 1) ? 32'hFFFF_FFFF : $urandom);
    end
    // full queue: plain overflow, overflow with zero priority, peek, unused, dequeue
    send(REQ_ENQ, 8'd7, 32'h5A5A_A5A5);
    send(REQ_ENQ, 8'd0, 32'hA5A5_5A5A);
    send(REQ_PEEK, 8'd0, 32'h0);
    send(REQ_UNUSED, 8'd0, 32'h0);
    send(REQ_DEQ, 8'd0, 32'h0);
    drain();

    // random part under each idle and stall pattern
    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 51; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 51; end
        default: begin idle_pct = 6; stall_pct = 6; end
      endcase
      for (burst = 0; burst < BURSTS; burst++) begin
        for (k = 0; k < BURST_ITEMS; k++) send_random(burst % 2 == 0);
      end
      // long receiver hold-off while requests keep coming
      if (phase == 0) begin
        stalls_asked++;
        for (k = 0; k < 40; k++) send_random(1'b1);
      end
      drain();
    end

    repeat (QUEUE_DEPTH + 4) @(posedge clk);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

@@ sorted_priority_queue.f @@
src/spq_pkg.sv
src/spq_if.sv
src/spq_slot_ram.sv
src/sorted_priority_queue.sv
test/spq_checker.sv
test/sorted_priority_queue_test.sv
